// ----- sv/bdq_pkg.sv -----
// Shared constants, types and helpers for the bounded deque with indexed read.
`timescale 1ns / 1ps

package bdq_pkg;

  // Store geometry.
  localparam int CAPACITY = 256;
  localparam int ELEM_W   = 32;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;

  // Port field widths.
  localparam int OPCODE_W = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_REM_HEAD = 3'd2,
    OP_REM_TAIL = 3'd3,
    OP_RD_HEAD  = 3'd4,
    OP_RD_TAIL  = 3'd5,
    OP_RD_POS   = 3'd6
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // One access to the element store.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [ELEM_W-1:0] wdata;
  } mem_req_t;

  // What the result of one operation needs besides the read data.
  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] count;
    logic             rd;
  } res_info_t;

  // Store entry of list position off, wrapped around the capacity.
  // The offset is always below CAPACITY, so one subtraction suffices.
  function automatic logic [ADDR_W-1:0] slot_of(logic [ADDR_W-1:0] head,
                                                logic [CNT_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ----- sv/bdq_mem.sv -----
// Element store: single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps

module bdq_mem import bdq_pkg::*; (
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [ELEM_W-1:0] rdata_o
);

  logic [ELEM_W-1:0] mem [CAPACITY];
  logic [ELEM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/bdq_ctrl.sv -----
// Head pointer and count registers, operation decode and store addressing.
`timescale 1ns / 1ps

module bdq_ctrl import bdq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [DATA_W-1:0]   element_i,
  input  logic [POS_W-1:0]    position_i,
  output mem_req_t            req_o,
  output res_info_t           info_o
);

  logic [ADDR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] head_dec;
  logic              full, empty, pos_ok;
  status_e           status;
  logic              we, re, rd;
  logic [ADDR_W-1:0] addr;

  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign pos_ok   = (CMP_W'(position_i) < CMP_W'(count_q));
  assign head_dec = (head_q == '0) ? ADDR_W'(CAPACITY - 1) : head_q - ADDR_W'(1);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    status  = ST_OK;
    we      = 1'b0;
    re      = 1'b0;
    rd      = 1'b0;
    addr    = head_q;
    unique case (opcode_e'(opcode_i))
      OP_INS_HEAD: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          we      = 1'b1;
          addr    = head_dec;
          head_d  = head_dec;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_INS_TAIL: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          we      = 1'b1;
          addr    = slot_of(head_q, count_q);
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REM_HEAD: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          head_d  = slot_of(head_q, CNT_W'(1));
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_REM_TAIL: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_RD_HEAD: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          re = 1'b1;
          rd = 1'b1;
        end
      end
      OP_RD_TAIL: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          re   = 1'b1;
          rd   = 1'b1;
          addr = slot_of(head_q, count_q - CNT_W'(1));
        end
      end
      OP_RD_POS: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          re   = 1'b1;
          rd   = 1'b1;
          addr = slot_of(head_q, CNT_W'(position_i));
        end
      end
      default: begin
        // The unused opcode is a no-operation.
      end
    endcase
  end

  assign req_o.we    = fire_i && we;
  assign req_o.re    = fire_i && re;
  assign req_o.addr  = addr;
  assign req_o.wdata = ELEM_W'(element_i);

  assign info_o.status = status;
  assign info_o.count  = count_d;
  assign info_o.rd     = rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (fire_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("element count exceeds capacity");

  a_one_access : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_o.we && req_o.re))
    else $error("store read and write in the same cycle");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && full && (opcode_i == OP_INS_HEAD || opcode_i == OP_INS_TAIL)
    |=> $stable(count_q) && $stable(head_q))
    else $error("insert into a full list changed the state");

  a_rem_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !empty && opcode_i == OP_REM_TAIL
    |=> count_q == $past(count_q) - CNT_W'(1) && $stable(head_q))
    else $error("remove tail did not shrink the list by one");

endmodule

// ----- sv/bounded_deque_with_indexed_read.sv -----
// Channel     Handshake                 Payload
// input       in_valid_i / in_ready_o   opcode_i, element_i, position_i
// output      out_valid_o / out_ready_i read_data_o, status_o, count_o
//
// One operation per cycle is accepted while in_ready_o is high; its result passes
// through the registered store read and result stage, then the output register.
// Reset clears the head pointer and count; the store itself is not cleared.
// A result stage and the output register each hold one result, so input stalls
// only when both are full and the output side is not taking a transfer.
`timescale 1ns / 1ps

module bounded_deque_with_indexed_read import bdq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [DATA_W-1:0]   element_i,
  input  logic [POS_W-1:0]    position_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DATA_W-1:0]   read_data_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [COUNT_W-1:0]  count_o
);

  mem_req_t          req;
  res_info_t         info;
  logic [ELEM_W-1:0] rdata;
  logic              fire, s1_adv;

  logic              s1_valid_q;
  res_info_t         s1_info_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  status_e           out_status_q;
  logic [CNT_W-1:0]  out_count_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign fire       = in_valid_i && in_ready_o;

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .opcode_i   (opcode_i),
    .element_i  (element_i),
    .position_i (position_i),
    .req_o      (req),
    .info_o     (info)
  );

  // The read data stays put while the result stage stalls, since no new
  // read can be issued until that stage moves on.
  bdq_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_info_q <= info;
    end
    if (s1_adv) begin
      out_data_q   <= s1_info_q.rd ? DATA_W'(rdata) : '0;
      out_status_q <= s1_info_q.status;
      out_count_q  <= s1_info_q.count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign status_o    = out_status_q;
  assign count_o     = COUNT_W'(out_count_q);

endmodule

// ----- dv/tb_bounded_deque_with_indexed_read.sv -----
// Self-checking testbench for the bounded deque with indexed read.
`timescale 1ns / 1ps

module tb_bounded_deque_with_indexed_read;
  import bdq_pkg::*;

  // Opcode value outside the enum; the block treats it as a no-op.
  localparam logic [OPCODE_W-1:0] OP_NOP = 3'd7;

  typedef struct {
    logic [DATA_W-1:0]  data;
    status_e            st;
    logic [COUNT_W-1:0] cnt;
  } deque_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready_o;
  logic [OPCODE_W-1:0] opcode;
  logic [DATA_W-1:0]   element;
  logic [POS_W-1:0]    position;
  logic                out_valid_o;
  logic                out_ready;
  logic [DATA_W-1:0]   read_data_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  count_o;

  // Shadow copy of the deque.
  logic [DATA_W-1:0] model_store [CAPACITY];
  int                model_head;
  int                model_count;

  deque_result_t awaited_results[$];

  int  errors;
  int  items_sent;
  int  results_checked;
  int  input_stall_cycles;
  int  peak_count;
  int  full_rejects;
  int  empty_rejects;
  int  range_rejects;
  bit  tx_calm;
  bit  rx_calm;
  int  rx_hold_req;

  bounded_deque_with_indexed_read dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode),
    .element_i   (element),
    .position_i  (position),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .read_data_o (read_data_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return $urandom;
  endfunction

  function automatic int slot(int off);
    return (model_head + off) % CAPACITY;
  endfunction

  // Applies one operation to the shadow deque and queues the result it should give.
  task automatic predict_deque_op(input logic [OPCODE_W-1:0] op,
                                  input logic [DATA_W-1:0] elem,
                                  input logic [POS_W-1:0] pos);
    deque_result_t res;
    res.data = '0;
    res.st   = ST_OK;
    case (op)
      OP_INS_HEAD: begin
        if (model_count >= CAPACITY) begin
          res.st = ST_FULL;
        end else begin
          model_head = (model_head + CAPACITY - 1) % CAPACITY;
          model_store[model_head] = elem;
          model_count++;
        end
      end
      OP_INS_TAIL: begin
        if (model_count >= CAPACITY) begin
          res.st = ST_FULL;
        end else begin
          model_store[slot(model_count)] = elem;
          model_count++;
        end
      end
      OP_REM_HEAD: begin
        if (model_count == 0) begin
          res.st = ST_EMPTY;
        end else begin
          model_head = slot(1);
          model_count--;
        end
      end
      OP_REM_TAIL: begin
        if (model_count == 0) begin
          res.st = ST_EMPTY;
        end else begin
          model_count--;
        end
      end
      OP_RD_HEAD: begin
        if (model_count == 0) res.st = ST_EMPTY;
        else res.data = model_store[slot(0)];
      end
      OP_RD_TAIL: begin
        if (model_count == 0) res.st = ST_EMPTY;
        else res.data = model_store[slot(model_count - 1)];
      end
      OP_RD_POS: begin
        if (int'(pos) >= model_count) res.st = ST_RANGE;
        else res.data = model_store[slot(int'(pos))];
      end
      default: begin
      end
    endcase
    res.cnt = COUNT_W'(model_count);
    if (model_count > peak_count) peak_count = model_count;
    if (res.st == ST_FULL) full_rejects++;
    if (res.st == ST_EMPTY) empty_rejects++;
    if (res.st == ST_RANGE) range_rejects++;
    awaited_results.push_back(res);
  endtask

  // Called at a falling edge; returns at a falling edge with valid left high
  // only when the next transfer may follow at once.
  task automatic send_item(input logic [OPCODE_W-1:0] op,
                           input logic [DATA_W-1:0] elem,
                           input logic [POS_W-1:0] pos);
    int gap;
    in_valid = 1'b1;
    opcode   = op;
    element  = elem;
    position = pos;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_deque_op(op, elem, pos);
    items_sent++;
    @(negedge clk_i);
    gap = tx_calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // The sender stops until every queued result has come back.
  task automatic wait_all_results();
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // Result side: ready changes at the falling edge.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req > 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
        out_ready  = 1'b0;
        stall_left = gap_len();
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    deque_result_t exp_res;
    if (rst_ni && in_valid && in_ready_o !== 1'b1) input_stall_cycles++;
    if (rst_ni && out_valid_o === 1'b1 && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: read_data %0h status %0d count %0d",
               read_data_o, status_o, count_o);
        errors++;
      end else begin
        exp_res = awaited_results.pop_front();
        results_checked++;
        if (read_data_o !== exp_res.data) begin
          $error("read_data: expected %0h, got %0h", exp_res.data, read_data_o);
          errors++;
        end
        if (status_o !== exp_res.st) begin
          $error("status: expected %0d, got %0d", exp_res.st, status_o);
          errors++;
        end
        if (count_o !== exp_res.cnt) begin
          $error("count: expected %0d, got %0d", exp_res.cnt, count_o);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(OP_REM_HEAD, '0, '0);
    send_item(OP_REM_TAIL, '1, '1);
    send_item(OP_RD_HEAD, '0, '0);
    send_item(OP_RD_TAIL, '0, '0);
    send_item(OP_RD_POS, '0, 8'd0);
    send_item(OP_RD_POS, '0, 8'd255);
    send_item(OP_NOP, '1, '1);
    send_item(OP_INS_HEAD, 32'hFFFF_FFFF, '0);
    send_item(OP_INS_TAIL, 32'h0000_0000, '1);
    send_item(OP_INS_HEAD, 32'hA5A5_5A5A, '0);
    send_item(OP_RD_HEAD, '0, '0);
    send_item(OP_RD_TAIL, '0, '0);
    send_item(OP_RD_POS, '0, 8'd0);
    send_item(OP_RD_POS, '0, 8'd1);
    send_item(OP_RD_POS, '0, 8'd2);
    send_item(OP_RD_POS, '0, 8'd3);
    send_item(OP_RD_POS, '0, 8'd255);
    send_item(OP_NOP, rand_word(), 8'($urandom));
    send_item(OP_REM_HEAD, '0, '0);
    send_item(OP_REM_TAIL, '0, '0);
    send_item(OP_RD_HEAD, '0, '0);
    send_item(OP_REM_HEAD, '0, '0);
    send_item(OP_REM_TAIL, '0, '0);
    wait_all_results();
  endtask

  // Fills the list to capacity behind a long receiver hold-off, probes it
  // while full, then empties it again.
  task automatic test_fill_and_drain();
    int n;
    tx_calm     = 1'b1;
    rx_hold_req = 120;
    while (model_count < CAPACITY) begin
      if (model_count == 40) tx_calm = 1'b0;
      send_item($urandom_range(0, 1) ? OP_INS_HEAD : OP_INS_TAIL, rand_word(),
                8'($urandom));
    end
    send_item(OP_INS_HEAD, rand_word(), '0);
    send_item(OP_INS_TAIL, rand_word(), '0);
    send_item(OP_RD_POS, '0, 8'd255);
    send_item(OP_RD_POS, '0, 8'd0);
    send_item(OP_RD_HEAD, '0, '0);
    send_item(OP_RD_TAIL, '0, '0);
    for (n = 0; n < 12; n++) send_item(OP_RD_POS, '0, 8'($urandom));
    while (model_count > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(OP_RD_POS, '0, 8'($urandom_range(0, 255)));
      end
      send_item($urandom_range(0, 1) ? OP_REM_HEAD : OP_REM_TAIL, '0, '0);
    end
    send_item(OP_RD_TAIL, '0, '0);
    send_item(OP_RD_POS, '0, 8'd0);
    wait_all_results();
  endtask

  // Random operations; the insert bias shifts so the count sweeps its range.
  task automatic test_random_mix(input int n_items);
    int i;
    int r;
    int fill_bias;
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0]    pos;
    fill_bias = 70;
    for (i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: fill_bias = 10;
          1: fill_bias = 50;
          2: fill_bias = 85;
          default: fill_bias = 97;
        endcase
      end
      if (i % 150 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      if (i == n_items / 2) wait_all_results();
      pos = '0;
      r   = $urandom_range(0, 99);
      if (r < 5) begin
        op  = 3'($urandom_range(0, 7));
        pos = 8'($urandom);
      end else if (r < 55) begin
        if ($urandom_range(0, 99) < fill_bias) begin
          op = $urandom_range(0, 1) ? OP_INS_HEAD : OP_INS_TAIL;
        end else begin
          op = $urandom_range(0, 1) ? OP_REM_HEAD : OP_REM_TAIL;
        end
      end else if (r < 96) begin
        case ($urandom_range(0, 3))
          0: op = OP_RD_HEAD;
          1: op = OP_RD_TAIL;
          default: op = OP_RD_POS;
        endcase
        if (model_count > 0 && $urandom_range(0, 99) < 85) begin
          pos = 8'($urandom_range(0, model_count - 1));
        end else begin
          pos = 8'($urandom);
        end
      end else begin
        op  = OP_NOP;
        pos = 8'($urandom);
      end
      send_item(op, rand_word(), pos);
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    wait_all_results();
  endtask

  // Back-to-back offers against a stopped receiver, so the input must stall.
  task automatic test_backpressure();
    int i;
    tx_calm     = 1'b1;
    rx_hold_req = 60;
    for (i = 0; i < 40; i++) begin
      send_item(3'($urandom_range(0, 6)), rand_word(),
                8'($urandom_range(0, model_count > 0 ? model_count : 0)));
    end
    tx_calm = 1'b0;
    wait_all_results();
  endtask

  initial begin
    errors             = 0;
    items_sent         = 0;
    results_checked    = 0;
    input_stall_cycles = 0;
    peak_count         = 0;
    full_rejects       = 0;
    empty_rejects      = 0;
    range_rejects      = 0;
    tx_calm            = 1'b0;
    rx_calm            = 1'b0;
    rx_hold_req        = 0;
    model_head         = 0;
    model_count        = 0;
    rst_ni             = 1'b0;
    in_valid           = 1'b0;
    opcode             = '0;
    element            = '0;
    position           = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed();
    test_fill_and_drain();
    test_random_mix(1000);
    test_backpressure();

    $display("Ran %0d operations, checked %0d results, peak count %0d.",
             items_sent, results_checked, peak_count);
    $display("Rejects: %0d full, %0d empty, %0d range; %0d input stall cycles.",
             full_rejects, empty_rejects, range_rejects, input_stall_cycles);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timeout with %0d results outstanding.", awaited_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
